>>> rtl/pbrt_pkg.sv
package pbrt_pkg;

  // Field widths of one transaction in each direction.
  localparam int FUNC_W    = 3;
  localparam int PIECE_W   = 32;
  localparam int COUNT_W   = 7;
  localparam int OFFSET_W  = 23;
  localparam int STATUS_W  = 2;
  localparam int CHOSEN_W  = 6;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] BLK_LOG2_RESET = 5'd14;

  localparam int SLOTS_DEF      = 8;
  localparam int MAX_BLOCKS_DEF = 64;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ADD       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_NEXT      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RECEIVED  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SHOULD_WR = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR_REQ = 3'd5;
  localparam logic [FUNC_W-1:0] FN_FULL      = 3'd6;
  localparam logic [FUNC_W-1:0] FN_LIST      = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_PIECE  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NO_SLOT   = 2'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 2'd3;

  // Per-block states held in the block-state memory.
  localparam logic [1:0] BS_MISSING   = 2'd0;
  localparam logic [1:0] BS_REQUESTED = 2'd1;
  localparam logic [1:0] BS_HELD      = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [PIECE_W-1:0]  piece_number;
    logic [COUNT_W-1:0]  block_count;
    logic [OFFSET_W-1:0] byte_offset;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                flag;
    logic                all_requested;
    logic                block_found;
    logic [CHOSEN_W-1:0] req_block;
    logic [PIECE_W-1:0]  listed_piece;
    logic                last;
  } out_item_t;

endpackage

>>> rtl/pbrt_engine.sv
module pbrt_engine #(
  parameter int SLOTS      = pbrt_pkg::SLOTS_DEF,
  parameter int MAX_BLOCKS = pbrt_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  pbrt_pkg::in_item_t         item,
  input  logic [pbrt_pkg::CFG_W-1:0] blk_log2,
  output logic                       idle,
  output logic                       res_valid,
  output pbrt_pkg::out_item_t        res,
  input  logic                       res_ready
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCW = $clog2(SLOTS + 1);
  localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int IW  = (BW + 1 > pbrt_pkg::COUNT_W) ? BW + 1 : pbrt_pkg::COUNT_W;
  localparam int TW  = pbrt_pkg::PIECE_W + pbrt_pkg::COUNT_W;
  localparam int SD  = 1 << (SW + BW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIND, ST_FIND_CMP, ST_DISPATCH, ST_CLR, ST_BSCAN,
    ST_CHK1, ST_LIST, ST_LIST_OUT, ST_EMIT
  } state_t;

  state_t                            state_r, state_nxt;
  logic [pbrt_pkg::FUNC_W-1:0]       func_r, func_nxt;
  logic [pbrt_pkg::PIECE_W-1:0]      piece_r, piece_nxt;
  logic [pbrt_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [pbrt_pkg::OFFSET_W-1:0]     bidx_r, bidx_nxt;
  logic [pbrt_pkg::COUNT_W-1:0]      nb_r, nb_nxt;
  logic [SCW-1:0]                    s_r, s_nxt;
  logic [SW-1:0]                     free_r, free_nxt;
  logic                              free_ok_r, free_ok_nxt;
  logic                              found_r, found_nxt;
  logic [IW-1:0]                     iss_r, iss_nxt;
  logic                              pend_r, pend_nxt;
  logic [BW-1:0]                     pend_idx_r, pend_idx_nxt;
  logic                              pick_ok_r, pick_ok_nxt;
  logic [BW-1:0]                     pick_r, pick_nxt;
  logic                              miss2_r, miss2_nxt;
  logic [SLOTS-1:0]                  used_r, used_nxt;
  pbrt_pkg::out_item_t               res_r, res_nxt;

  // Slot table: {block count, piece number} per slot.
  logic [TW-1:0] tbl_mem [SLOTS];
  logic [TW-1:0] tbl_rd_r;
  logic          tbl_we, tbl_re;
  logic [SW-1:0] tbl_waddr, tbl_raddr;
  logic [TW-1:0] tbl_wdata;

  // Block-state memory, addressed by {slot, block}.
  logic [1:0]       st_mem [SD];
  logic [1:0]       st_rd_r;
  logic             st_we, st_re;
  logic [SW+BW-1:0] st_waddr, st_raddr;
  logic [1:0]       st_wdata;

  logic [SW-1:0]    slot;
  logic [SW-1:0]    tgt;
  logic             used_above;
  logic             bad_idx;
  logic [pbrt_pkg::PIECE_W-1:0] rd_piece;
  logic [pbrt_pkg::COUNT_W-1:0] rd_count;
  pbrt_pkg::out_item_t          list_res;

  assign slot     = s_r[SW-1:0];
  assign tgt      = found_r ? slot : free_r;
  assign rd_piece = tbl_rd_r[pbrt_pkg::PIECE_W-1:0];
  assign rd_count = tbl_rd_r[TW-1:pbrt_pkg::PIECE_W];
  assign bad_idx  = bidx_r >= pbrt_pkg::OFFSET_W'(nb_r);
  assign idle     = (state_r == ST_IDLE);

  always_comb begin
    used_above = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if (SCW'(k) > s_r && used_r[k]) used_above = 1'b1;
    end
  end

  always_comb begin
    list_res              = '0;
    list_res.status       = pbrt_pkg::STS_DONE;
    list_res.flag         = 1'b1;
    list_res.listed_piece = rd_piece;
    list_res.last         = !used_above;
  end

  assign res_valid = (state_r == ST_EMIT) || (state_r == ST_LIST_OUT);
  assign res       = (state_r == ST_LIST_OUT) ? list_res : res_r;

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    piece_nxt    = piece_r;
    count_nxt    = count_r;
    bidx_nxt     = bidx_r;
    nb_nxt       = nb_r;
    s_nxt        = s_r;
    free_nxt     = free_r;
    free_ok_nxt  = free_ok_r;
    found_nxt    = found_r;
    iss_nxt      = iss_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    pick_ok_nxt  = pick_ok_r;
    pick_nxt     = pick_r;
    miss2_nxt    = miss2_r;
    used_nxt     = used_r;
    res_nxt      = res_r;
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    tbl_waddr    = tgt;
    tbl_raddr    = slot;
    tbl_wdata    = {count_r, piece_r};
    st_we        = 1'b0;
    st_re        = 1'b0;
    st_waddr     = {slot, pend_idx_r};
    st_raddr     = {slot, iss_r[BW-1:0]};
    st_wdata     = pbrt_pkg::BS_MISSING;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt     = item.func;
          piece_nxt    = item.piece_number;
          count_nxt    = item.block_count;
          bidx_nxt     = item.byte_offset >> blk_log2;
          s_nxt        = '0;
          free_ok_nxt  = 1'b0;
          found_nxt    = 1'b0;
          res_nxt      = '0;
          res_nxt.last = 1'b1;
          case (item.func)
            pbrt_pkg::FN_LIST: begin
              state_nxt = (used_r == '0) ? ST_EMIT : ST_LIST;
            end
            pbrt_pkg::FN_FULL: begin
              res_nxt.flag = &used_r;
              state_nxt    = ST_EMIT;
            end
            pbrt_pkg::FN_ADD: begin
              if (item.block_count == '0 ||
                  32'(item.block_count) > 32'(MAX_BLOCKS)) begin
                res_nxt.status = pbrt_pkg::STS_BAD_INDEX;
                state_nxt      = ST_EMIT;
              end else begin
                state_nxt = ST_FIND;
              end
            end
            default: state_nxt = ST_FIND;
          endcase
        end
      end

      ST_FIND: begin
        if (s_r == SCW'(SLOTS)) begin
          state_nxt = ST_DISPATCH;
        end else if (used_r[slot]) begin
          tbl_re    = 1'b1;
          state_nxt = ST_FIND_CMP;
        end else begin
          if (!free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt    = slot;
          end
          s_nxt = s_r + SCW'(1);
        end
      end

      ST_FIND_CMP: begin
        if (rd_piece == piece_r) begin
          found_nxt = 1'b1;
          nb_nxt    = rd_count;
          state_nxt = ST_DISPATCH;
        end else begin
          s_nxt     = s_r + SCW'(1);
          state_nxt = ST_FIND;
        end
      end

      ST_DISPATCH: begin
        iss_nxt     = '0;
        pend_nxt    = 1'b0;
        pick_ok_nxt = 1'b0;
        miss2_nxt   = 1'b0;
        state_nxt   = ST_EMIT;
        if (func_r == pbrt_pkg::FN_ADD) begin
          if (!found_r && !free_ok_r) begin
            res_nxt.status = pbrt_pkg::STS_NO_SLOT;
          end else begin
            tbl_we        = 1'b1;
            used_nxt[tgt] = 1'b1;
            s_nxt         = SCW'(tgt);
            res_nxt.flag  = 1'b1;
            state_nxt     = ST_CLR;
          end
        end else if (!found_r) begin
          res_nxt.status = pbrt_pkg::STS_NO_PIECE;
        end else begin
          case (func_r)
            pbrt_pkg::FN_NEXT, pbrt_pkg::FN_CLEAR_REQ: state_nxt = ST_BSCAN;
            pbrt_pkg::FN_RECEIVED: begin
              if (bad_idx) res_nxt.status = pbrt_pkg::STS_BAD_INDEX;
              else         state_nxt = ST_BSCAN;
            end
            pbrt_pkg::FN_SHOULD_WR: begin
              if (bad_idx) begin
                res_nxt.status = pbrt_pkg::STS_BAD_INDEX;
              end else begin
                st_re     = 1'b1;
                st_raddr  = {slot, bidx_r[BW-1:0]};
                state_nxt = ST_CHK1;
              end
            end
            pbrt_pkg::FN_REMOVE: used_nxt[slot] = 1'b0;
            default: ;
          endcase
        end
      end

      // Reset a freshly added slot: one block a cycle goes to missing.
      ST_CLR: begin
        st_we    = 1'b1;
        st_waddr = {slot, iss_r[BW-1:0]};
        st_wdata = pbrt_pkg::BS_MISSING;
        iss_nxt  = iss_r + IW'(1);
        if (iss_r == IW'(count_r - pbrt_pkg::COUNT_W'(1))) state_nxt = ST_EMIT;
      end

      // Walk the blocks of the slot: one read issued and one checked per cycle.
      ST_BSCAN: begin
        if (iss_r < IW'(nb_r)) begin
          st_re        = 1'b1;
          iss_nxt      = iss_r + IW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_r[BW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          case (func_r)
            pbrt_pkg::FN_NEXT: begin
              if (st_rd_r == pbrt_pkg::BS_MISSING) begin
                if (!pick_ok_r) begin
                  pick_ok_nxt = 1'b1;
                  pick_nxt    = pend_idx_r;
                end else begin
                  miss2_nxt = 1'b1;
                end
              end
            end
            pbrt_pkg::FN_RECEIVED: begin
              if (pend_idx_r != bidx_r[BW-1:0] && st_rd_r != pbrt_pkg::BS_HELD)
                miss2_nxt = 1'b1;
            end
            default: begin
              if (st_rd_r == pbrt_pkg::BS_REQUESTED) begin
                st_we    = 1'b1;
                st_waddr = {slot, pend_idx_r};
                st_wdata = pbrt_pkg::BS_MISSING;
              end
            end
          endcase
        end else if (iss_r >= IW'(nb_r)) begin
          state_nxt = ST_EMIT;
          case (func_r)
            pbrt_pkg::FN_NEXT: begin
              if (pick_ok_r) begin
                st_we    = 1'b1;
                st_waddr = {slot, pick_r};
                st_wdata = pbrt_pkg::BS_REQUESTED;
              end
              res_nxt.block_found   = pick_ok_r;
              res_nxt.req_block     = pick_ok_r ? pbrt_pkg::CHOSEN_W'(pick_r) : '0;
              res_nxt.all_requested = !miss2_r;
            end
            pbrt_pkg::FN_RECEIVED: begin
              st_we        = 1'b1;
              st_waddr     = {slot, bidx_r[BW-1:0]};
              st_wdata     = pbrt_pkg::BS_HELD;
              res_nxt.flag = !miss2_r;
            end
            default: ;
          endcase
        end
      end

      ST_CHK1: begin
        res_nxt.flag = (st_rd_r != pbrt_pkg::BS_HELD);
        state_nxt    = ST_EMIT;
      end

      // A later occupied slot always exists while this state is reached.
      ST_LIST: begin
        if (used_r[slot]) begin
          tbl_re    = 1'b1;
          state_nxt = ST_LIST_OUT;
        end else begin
          s_nxt = s_r + SCW'(1);
        end
      end

      ST_LIST_OUT: begin
        if (res_ready) begin
          if (!used_above) begin
            state_nxt = ST_IDLE;
          end else begin
            s_nxt     = s_r + SCW'(1);
            state_nxt = ST_LIST;
          end
        end
      end

      ST_EMIT: begin
        if (res_ready) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    piece_r    <= piece_nxt;
    count_r    <= count_nxt;
    bidx_r     <= bidx_nxt;
    nb_r       <= nb_nxt;
    s_r        <= s_nxt;
    free_r     <= free_nxt;
    free_ok_r  <= free_ok_nxt;
    found_r    <= found_nxt;
    iss_r      <= iss_nxt;
    pend_idx_r <= pend_idx_nxt;
    pick_ok_r  <= pick_ok_nxt;
    pick_r     <= pick_nxt;
    miss2_r    <= miss2_nxt;
    res_r      <= res_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_re) st_rd_r <= st_mem[st_raddr];
  end

endmodule

>>> rtl/piece_block_request_tracker_unit.sv
// Piece block request tracker.
// Input channel (in_valid, in_stall, in_data) takes one operation per transaction:
// add a piece, pick the next missing block, record a received block, ask whether a
// block is still wanted, remove a piece, return requested blocks to missing, test
// for a full buffer, or list the occupied pieces. Results leave on the output
// channel (out_valid, out_stall, out_data); each operation gives one transaction,
// a list gives one per occupied slot (one if none is), and the final one carries last.
// The configuration channel (cfg_valid, cfg_ready, cfg_wdata) sets log2 of the
// block length and should be written only while the block is idle.
// One operation is worked at a time; in_stall stays high until its last result
// has been loaded into the output register. Full, empty list and a rejected add
// go straight to the result state. The piece search reads the table entry of each
// occupied slot, skipping free ones; add then clears its blocks at one a cycle,
// and next-block, received and clear-requested walk the piece's blocks at one a
// cycle through the single read port of the block-state memory.
// Reset marks every slot free and loads a block size of 16 KiB; no memory is
// cleared. While out_stall is high and out_valid is set, the output register holds
// its transaction and the engine waits with the next result.
module piece_block_request_tracker_unit #(
  parameter int SLOTS      = pbrt_pkg::SLOTS_DEF,
  parameter int MAX_BLOCKS = pbrt_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pbrt_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pbrt_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pbrt_pkg::CFG_W-1:0] cfg_wdata
);

  logic [pbrt_pkg::CFG_W-1:0] blk_log2_r;
  logic                       out_valid_r;
  pbrt_pkg::out_item_t        out_data_r;
  logic                       eng_idle;
  logic                       res_valid;
  logic                       res_ready;
  pbrt_pkg::out_item_t        res;

  // The register can always be written; keeping writes to idle is up to software.
  assign cfg_ready = 1'b1;

  assign in_stall  = !eng_idle;

  // A new result may enter when the output register is empty or being emptied.
  assign res_ready = !out_valid_r || !out_stall;

  pbrt_engine #(
    .SLOTS      (SLOTS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && !in_stall),
    .item      (in_data),
    .blk_log2  (blk_log2_r),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data_r <= res;
    if (!rst_n) begin
      blk_log2_r  <= pbrt_pkg::BLK_LOG2_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) blk_log2_r <= cfg_wdata;
      if (res_ready) out_valid_r <= res_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/pbrt_checker.sv
module pbrt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input pbrt_pkg::out_item_t        out_data
);

  // A stalled result transaction is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // Operations are worked one at a time: the input closes after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again while an operation is in progress");

  // No result survives reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // An error result never reports success or a found block.
  a_error_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != pbrt_pkg::STS_DONE |->
      !out_data.flag && !out_data.block_found && out_data.last)
    else $error("error result carries a set flag or is not last");

endmodule

bind piece_block_request_tracker_unit pbrt_checker u_pbrt_checker (.*);

>>> tb/piece_block_request_tracker_unit_test.sv
`timescale 1ns / 1ps

module piece_block_request_tracker_unit_test;

  localparam int SLOTS      = pbrt_pkg::SLOTS_DEF;
  localparam int MAX_BLOCKS = pbrt_pkg::MAX_BLOCKS_DEF;
  localparam int PHASES     = 6;
  localparam int PHASE_OPS  = 52;
  localparam int POOL_SIZE  = 12;

  // Clock, reset and the three channels. Every input has a known value from time zero.
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  pbrt_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  pbrt_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [pbrt_pkg::CFG_W-1:0]    cfg_wdata = pbrt_pkg::BLK_LOG2_RESET;

  // A directed row may carry a hand-written result. It travels with the operation as a
  // sideband, driven at the same edge as in_data, so that the monitor sees the pair together.
  logic                          pin_set = 1'b0;
  pbrt_pkg::out_item_t           pin_res = '0;

  // Shadow of the tracker: slot table, per-block states and the block size.
  bit                            slot_busy [SLOTS];
  logic [pbrt_pkg::PIECE_W-1:0]  slot_pc [SLOTS];
  logic [pbrt_pkg::COUNT_W-1:0]  slot_nb [SLOTS];
  logic [1:0]                    blk_st [SLOTS][MAX_BLOCKS];
  logic [pbrt_pkg::CFG_W-1:0]    blk_log2 = pbrt_pkg::BLK_LOG2_RESET;

  // Results the tracker still owes us, oldest first.
  pbrt_pkg::out_item_t           awaited_results [$];

  typedef struct {
    pbrt_pkg::in_item_t  op;
    bit                  pinned;
    pbrt_pkg::out_item_t res;
  } dir_row_t;

  dir_row_t                      dir_tab [$];
  logic [pbrt_pkg::PIECE_W-1:0]  piece_pool [POOL_SIZE];
  logic [pbrt_pkg::CFG_W-1:0]    phase_log2 [PHASES] =
    '{5'd10, 5'd17, 5'd0, 5'd31, 5'd12, 5'd14};
  bit                            src_pauses = 1'b1;
  logic                          sink_pauses = 1'b1;
  int                            stall_left = 0;
  int                            n_fail = 0;

  piece_block_request_tracker_unit #(
    .SLOTS      (SLOTS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Overall guard. The slowest legal run (every operation walking a full piece, every
  // result held back by the longest stall) stays well under a tenth of this.
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // Lookup by piece number: the first occupied slot that holds it, or -1.
  function automatic int slot_of(logic [pbrt_pkg::PIECE_W-1:0] pc);
    for (int k = 0; k < SLOTS; k++)
      if (slot_busy[k] && slot_pc[k] == pc) return k;
    return -1;
  endfunction

  // Applies one operation to the shadow state and queues the result transactions it
  // should produce. A list gives one transaction per occupied slot, anything else one.
  function automatic void apply_tracker_op(pbrt_pkg::in_item_t op);
    pbrt_pkg::out_item_t r;
    int s;
    int n;
    int nb;
    logic [pbrt_pkg::OFFSET_W-1:0] idx;
    r = '0;
    r.last = 1'b1;
    idx = op.byte_offset >> blk_log2;
    s = slot_of(op.piece_number);
    nb = (s >= 0) ? int'(slot_nb[s]) : 0;
    case (op.func)
      pbrt_pkg::FN_LIST: begin
        n = 0;
        for (int k = 0; k < SLOTS; k++) begin
          if (slot_busy[k]) begin
            r = '0;
            r.flag = 1'b1;
            r.listed_piece = slot_pc[k];
            awaited_results = {awaited_results, r};
            n++;
          end
        end
        // An empty table still answers, with a single blank transaction.
        if (n == 0) begin
          r = '0;
          r.last = 1'b1;
          awaited_results = {awaited_results, r};
        end else begin
          r = awaited_results.pop_back();
          r.last = 1'b1;
          awaited_results = {awaited_results, r};
        end
        return;
      end
      pbrt_pkg::FN_FULL: begin
        r.flag = 1'b1;
        for (int k = 0; k < SLOTS; k++)
          if (!slot_busy[k]) r.flag = 1'b0;
      end
      pbrt_pkg::FN_ADD: begin
        if (op.block_count == 0 || op.block_count > MAX_BLOCKS) begin
          r.status = pbrt_pkg::STS_BAD_INDEX;
        end else begin
          // A piece already present is reset where it stands; otherwise the first free slot.
          for (int k = 0; k < SLOTS; k++)
            if (s < 0 && !slot_busy[k]) s = k;
          if (s < 0) begin
            r.status = pbrt_pkg::STS_NO_SLOT;
          end else begin
            slot_busy[s] = 1'b1;
            slot_pc[s] = op.piece_number;
            slot_nb[s] = op.block_count;
            for (int b = 0; b < MAX_BLOCKS; b++) blk_st[s][b] = pbrt_pkg::BS_MISSING;
            r.flag = 1'b1;
          end
        end
      end
      default: begin
        if (s < 0) begin
          r.status = pbrt_pkg::STS_NO_PIECE;
        end else begin
          case (op.func)
            pbrt_pkg::FN_NEXT: begin
              for (int b = 0; b < nb; b++) begin
                if (!r.block_found && blk_st[s][b] == pbrt_pkg::BS_MISSING) begin
                  blk_st[s][b] = pbrt_pkg::BS_REQUESTED;
                  r.block_found = 1'b1;
                  r.req_block = pbrt_pkg::CHOSEN_W'(b);
                end
              end
              r.all_requested = 1'b1;
              for (int b = 0; b < nb; b++)
                if (blk_st[s][b] == pbrt_pkg::BS_MISSING) r.all_requested = 1'b0;
            end
            pbrt_pkg::FN_RECEIVED: begin
              if (idx >= nb) begin
                r.status = pbrt_pkg::STS_BAD_INDEX;
              end else begin
                blk_st[s][idx] = pbrt_pkg::BS_HELD;
                r.flag = 1'b1;
                for (int b = 0; b < nb; b++)
                  if (blk_st[s][b] != pbrt_pkg::BS_HELD) r.flag = 1'b0;
              end
            end
            pbrt_pkg::FN_SHOULD_WR: begin
              if (idx >= nb) r.status = pbrt_pkg::STS_BAD_INDEX;
              else r.flag = (blk_st[s][idx] != pbrt_pkg::BS_HELD);
            end
            pbrt_pkg::FN_REMOVE: begin
              slot_busy[s] = 1'b0;
            end
            default: begin
              // Clear requested: anything in flight goes back to missing.
              for (int b = 0; b < nb; b++)
                if (blk_st[s][b] == pbrt_pkg::BS_REQUESTED)
                  blk_st[s][b] = pbrt_pkg::BS_MISSING;
            end
          endcase
        end
      end
    endcase
    awaited_results = {awaited_results, r};
  endfunction

  task automatic match_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", fname, want_v, got_v);
      n_fail++;
    end
  endtask

  // Monitor. All sampling happens on the rising edge and sees the values from before it,
  // so nothing here depends on the order in which processes wake. The output is checked
  // before the new operation is predicted: a result can never belong to an operation
  // taken at the same edge.
  always @(posedge clk) begin
    pbrt_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with nothing outstanding: %p", out_data);
          n_fail++;
        end else begin
          want = awaited_results.pop_front();
          match_field("status", want.status, out_data.status);
          match_field("flag", want.flag, out_data.flag);
          match_field("all_requested", want.all_requested, out_data.all_requested);
          match_field("block_found", want.block_found, out_data.block_found);
          match_field("req_block", want.req_block, out_data.req_block);
          match_field("listed_piece", want.listed_piece, out_data.listed_piece);
          match_field("last", want.last, out_data.last);
        end
      end
      if (cfg_valid && cfg_ready) blk_log2 = cfg_wdata;
      if (in_valid && !in_stall) begin
        apply_tracker_op(in_data);
        // Hand-written rows are single-result operations; their result replaces the shadow's.
        if (pin_set) begin
          void'(awaited_results.pop_back());
          awaited_results = {awaited_results, pin_res};
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts, dropped entirely when quiet.
  always @(posedge clk) begin
    if (!rst_n || !sink_pauses) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one operation, possibly after a gap, and returns at the edge that accepts it.
  // Valid is left high so that a following operation is offered without a gap.
  task automatic send_op(pbrt_pkg::in_item_t op, bit pinned, pbrt_pkg::out_item_t res);
    if (src_pauses && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    pin_set <= pinned;
    pin_res <= res;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets every outstanding result come home, then gives the engine time to finish tidying
  // up before the block size is touched.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_block_log2(logic [pbrt_pkg::CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(logic [pbrt_pkg::FUNC_W-1:0] fn,
                                  logic [pbrt_pkg::PIECE_W-1:0] pc,
                                  logic [pbrt_pkg::COUNT_W-1:0] cnt,
                                  logic [pbrt_pkg::OFFSET_W-1:0] off,
                                  bit pinned, logic [pbrt_pkg::STATUS_W-1:0] st,
                                  logic fl);
    dir_row_t row;
    row.op = '0;
    row.op.func = fn;
    row.op.piece_number = pc;
    row.op.block_count = cnt;
    row.op.byte_offset = off;
    row.pinned = pinned;
    row.res = '0;
    row.res.status = st;
    row.res.flag = fl;
    row.res.last = 1'b1;
    dir_tab = {dir_tab, row};
  endfunction

  // Random operation. Most name a piece that is really in the table and a block inside
  // it, so the traffic walks through request, receipt and completion; the remainder are
  // unknown pieces, stray offsets and bad block counts.
  function automatic pbrt_pkg::in_item_t draw_op();
    pbrt_pkg::in_item_t op;
    int roll;
    int s;
    int nb;
    int b;
    int live [$];
    longint unsigned off;
    op.piece_number = $urandom();
    op.block_count = pbrt_pkg::COUNT_W'($urandom());
    op.byte_offset = pbrt_pkg::OFFSET_W'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < 14) op.func = pbrt_pkg::FN_ADD;
    else if (roll < 40) op.func = pbrt_pkg::FN_NEXT;
    else if (roll < 66) op.func = pbrt_pkg::FN_RECEIVED;
    else if (roll < 78) op.func = pbrt_pkg::FN_SHOULD_WR;
    else if (roll < 85) op.func = pbrt_pkg::FN_REMOVE;
    else if (roll < 90) op.func = pbrt_pkg::FN_CLEAR_REQ;
    else if (roll < 94) op.func = pbrt_pkg::FN_FULL;
    else op.func = pbrt_pkg::FN_LIST;
    for (int k = 0; k < SLOTS; k++)
      if (slot_busy[k]) live = {live, k};
    roll = $urandom_range(0, 99);
    if (op.func == pbrt_pkg::FN_ADD) begin
      if (roll < 80) op.piece_number = piece_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (roll < 90 && live.size() != 0)
        op.piece_number = slot_pc[live[$urandom_range(0, live.size() - 1)]];
      roll = $urandom_range(0, 99);
      if (roll < 70) op.block_count = pbrt_pkg::COUNT_W'($urandom_range(1, 8));
      else if (roll < 90)
        op.block_count = pbrt_pkg::COUNT_W'($urandom_range(9, MAX_BLOCKS));
      else if (roll < 93) op.block_count = '0;
      else op.block_count = pbrt_pkg::COUNT_W'($urandom_range(MAX_BLOCKS + 1, 127));
    end else if (roll < 85 && live.size() != 0) begin
      s = live[$urandom_range(0, live.size() - 1)];
      nb = slot_nb[s];
      op.piece_number = slot_pc[s];
      if ($urandom_range(0, 99) < 85) b = $urandom_range(0, nb - 1);
      else b = $urandom_range(nb, nb + 4);
      // Block index in the upper bits, random bytes within the block below it.
      off = (64'(b) << blk_log2) | (64'($urandom()) & ((64'd1 << blk_log2) - 1));
      op.byte_offset = off[pbrt_pkg::OFFSET_W-1:0];
    end else if (roll < 93) begin
      op.piece_number = piece_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return op;
  endfunction

  initial begin
    // Directed part, run at the reset block size of 16 KiB. Results that can be read off
    // at a glance are written in; the rest come from the shadow model.
    add_row(pbrt_pkg::FN_FULL, '0, '0, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_LIST, '0, '0, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_ADD, 32'h0, 7'd0, '0, 1'b1, pbrt_pkg::STS_BAD_INDEX, 1'b0);
    add_row(pbrt_pkg::FN_ADD, 32'hFFFF_FFFF, 7'd127, '0, 1'b1,
            pbrt_pkg::STS_BAD_INDEX, 1'b0);
    add_row(pbrt_pkg::FN_ADD, 32'h0, 7'd64, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    add_row(pbrt_pkg::FN_ADD, 32'hFFFF_FFFF, 7'd1, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    // The one-block piece: request it, then ask again with nothing left to pick.
    add_row(pbrt_pkg::FN_NEXT, 32'hFFFF_FFFF, '0, '0, 1'b0, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_NEXT, 32'hFFFF_FFFF, '0, '0, 1'b0, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_RECEIVED, 32'hFFFF_FFFF, '0, 23'h4000, 1'b1,
            pbrt_pkg::STS_BAD_INDEX, 1'b0);
    add_row(pbrt_pkg::FN_RECEIVED, 32'hFFFF_FFFF, '0, 23'h3FFF, 1'b0,
            pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_SHOULD_WR, 32'hFFFF_FFFF, '0, '0, 1'b0, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_RECEIVED, 32'h0, '0, 23'h7F_FFFF, 1'b1,
            pbrt_pkg::STS_BAD_INDEX, 1'b0);
    add_row(pbrt_pkg::FN_SHOULD_WR, 32'h0, '0, 23'h7C_0000, 1'b0,
            pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_NEXT, 32'h0, '0, '0, 1'b0, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_CLEAR_REQ, 32'h0, '0, '0, 1'b0, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_ADD, 32'h0, 7'd65, '0, 1'b1, pbrt_pkg::STS_BAD_INDEX, 1'b0);
    // Adding a piece that is already present starts it again in the same slot.
    add_row(pbrt_pkg::FN_ADD, 32'h0, 7'd2, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    // Fill the remaining six slots, then try one more.
    add_row(pbrt_pkg::FN_ADD, 32'h0000_0001, 7'd3, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    add_row(pbrt_pkg::FN_ADD, 32'h8000_0000, 7'd16, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    add_row(pbrt_pkg::FN_ADD, 32'h5555_5555, 7'd32, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    add_row(pbrt_pkg::FN_ADD, 32'hAAAA_AAAA, 7'd63, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    add_row(pbrt_pkg::FN_ADD, 32'h0000_FFFF, 7'd8, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    add_row(pbrt_pkg::FN_ADD, 32'hFFFF_0000, 7'd4, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b1);
    add_row(pbrt_pkg::FN_ADD, 32'h1234_5678, 7'd5, '0, 1'b1, pbrt_pkg::STS_NO_SLOT, 1'b0);
    add_row(pbrt_pkg::FN_FULL, '0, '0, '0, 1'b0, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_LIST, '0, '0, '0, 1'b0, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_REMOVE, 32'hFFFF_FFFF, '0, '0, 1'b1, pbrt_pkg::STS_DONE, 1'b0);
    add_row(pbrt_pkg::FN_REMOVE, 32'hFFFF_FFFF, '0, '0, 1'b1,
            pbrt_pkg::STS_NO_PIECE, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_op(dir_tab[i].op, dir_tab[i].pinned, dir_tab[i].res);
    drain();

    // Random phases, each at its own block size: both range limits, the reset value, and
    // the out-of-range codes zero and 31. The final phase runs flat out with no idling.
    for (int p = 0; p < PHASES; p++) begin
      src_pauses = (p != 1) && (p != PHASES - 1);
      sink_pauses <= (p != 2) && (p != PHASES - 1);
      set_block_log2(phase_log2[p]);
      foreach (piece_pool[k]) piece_pool[k] = $urandom();
      repeat (PHASE_OPS) send_op(draw_op(), 1'b0, '0);
      drain();
    end

    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("awaited_results: expected 0, got %0d", awaited_results.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
